@@ design/ihb_pkg.sv @@
// Shared types, constants and checksum helpers for the IPv4 UDP/TCP header builder.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package ihb_pkg;

    // Sizing
    localparam int MAX_FRAGMENT = 1024;
    localparam int LEN_W        = 11;
    // worst-case sum of the 16-bit payload words of one fragment
    localparam int SUM_W        = $clog2(((MAX_FRAGMENT + 1) / 2) * 65535 + 1);
    // wide enough for payload sum plus the header terms before folding
    localparam int CSUM_W       = ((SUM_W > 16) ? SUM_W : 16) + 4;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 32;
    localparam int WIDX_W       = 5;

    localparam logic [LEN_W-1:0] MAX_FRAG_LEN    = LEN_W'(MAX_FRAGMENT);
    localparam logic [LEN_W-1:0] FRAG_SIZE_RESET = 11'd1024;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SRC_ADDR    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_PORT = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_USE_TCP     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAG_SIZE   = 4'd3;

    // Fixed header fields
    localparam logic [15:0] VER_IHL_TOS   = 16'h4500;
    localparam logic [15:0] IP_ID         = 16'd54321;
    localparam logic [7:0]  IP_TTL        = 8'd255;
    localparam logic [15:0] TCP_OFF_FLAGS = 16'h5002;
    localparam logic [15:0] TCP_WINDOW    = 16'd5840;
    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [15:0] IP_HDR_BYTES  = 16'd20;
    localparam logic [15:0] UDP_HDR_BYTES = 16'd8;
    localparam logic [15:0] TCP_HDR_BYTES = 16'd20;
    localparam logic [WIDX_W-1:0] UDP_WORDS = 5'd14;
    localparam logic [WIDX_W-1:0] TCP_WORDS = 5'd20;

    typedef struct packed {
        logic [31:0]      src_addr;
        logic [15:0]      source_port;
        logic             use_tcp;
        logic [LEN_W-1:0] frag_size;
    } cfg_t;

    // One closed fragment, handed from the front end to the back end
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [SUM_W-1:0] payload_sum;
        logic [31:0]      dst_addr;
        logic [15:0]      dst_port;
    } frag_desc_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CALC,
        BK_FOLD1,
        BK_FOLD2,
        BK_EMIT
    } back_state_t;

    function automatic logic [CSUM_W-1:0] ext16(input logic [15:0] x);
        return {{(CSUM_W - 16){1'b0}}, x};
    endfunction

    // One end-around carry step of the one's-complement sum
    function automatic logic [CSUM_W-1:0] fold_step(input logic [CSUM_W-1:0] s);
        return (s >> 16) + ext16(s[15:0]);
    endfunction

endpackage

`default_nettype wire

@@ design/ihb_if.sv @@
// Handshake channel interfaces: payload bytes in, header words out, register writes.
// Depends on ihb_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ihb_in_if
    import ihb_pkg::*;
;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic        last_of_message;
    logic [31:0] dst_addr;
    logic [15:0] dst_port;

    modport source (output valid, payload_byte, last_of_message, dst_addr, dst_port,
                    input ready);
    modport sink   (input valid, payload_byte, last_of_message, dst_addr, dst_port,
                    output ready);
endinterface

interface ihb_out_if
    import ihb_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [15:0]      header_word;
    logic [LEN_W-1:0] fragment_length;
    logic             last_word;

    modport source (output valid, header_word, fragment_length, last_word, input ready);
    modport sink   (input valid, header_word, fragment_length, last_word, output ready);
endinterface

interface ihb_cfg_if
    import ihb_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ design/ihb_front.sv @@
// Front end: takes payload bytes, sums 16-bit payload words, closes fragments.
// Depends on ihb_pkg and ihb_in_if; pushes fragment descriptors into ihb_queue.
`timescale 1ns / 1ps
`default_nettype none

module ihb_front
    import ihb_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire cfg_t   cfg,
    ihb_in_if.sink      msg,
    input  wire logic   q_full,
    output logic        q_push,
    output frag_desc_t  q_desc
);

    logic [LEN_W-1:0] count_reg, count_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [7:0]       pend_reg, pend_next;

    logic             accept;
    logic             even;
    logic [15:0]      word;
    logic [LEN_W-1:0] count_inc;
    logic [LEN_W-1:0] limit;
    logic             close;
    logic [SUM_W-1:0] sum_with_word;

    assign msg.ready = !q_full;
    assign accept    = msg.valid && msg.ready;

    // Effective fragment size: zero acts as one, oversize saturates
    always_comb
    begin
        if (cfg.frag_size == '0)
            limit = LEN_W'(1);
        else if (cfg.frag_size > MAX_FRAG_LEN)
            limit = MAX_FRAG_LEN;
        else
            limit = cfg.frag_size;
    end

    // Byte pairing; an odd closing byte pairs with a zero low byte
    assign even          = !count_reg[0];
    assign word          = even ? {msg.payload_byte, 8'h00} : {pend_reg, msg.payload_byte};
    assign count_inc     = count_reg + LEN_W'(1);
    assign close         = msg.last_of_message || (count_inc >= limit);
    assign sum_with_word = sum_reg + SUM_W'(word);

    assign q_push = accept && close;

    // Descriptor of the fragment closed by this byte
    always_comb
    begin
        q_desc.len         = count_inc;
        q_desc.payload_sum = sum_with_word;
        q_desc.dst_addr    = msg.dst_addr;
        q_desc.dst_port    = msg.dst_port;
    end

    // Accumulator next state
    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        pend_next  = pend_reg;
        if (accept)
        begin
            if (close)
            begin
                count_next = '0;
                sum_next   = '0;
                pend_next  = '0;
            end
            else
            begin
                count_next = count_inc;
                if (even)
                    pend_next = msg.payload_byte;
                else
                    sum_next = sum_with_word;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            pend_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

`default_nettype wire

@@ design/ihb_queue.sv @@
// Small descriptor FIFO between the front end and the header back end.
// Depends on ihb_pkg for frag_desc_t and the depth constants.
`timescale 1ns / 1ps
`default_nettype none

module ihb_queue
    import ihb_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire frag_desc_t push_desc,
    output logic            full,
    input  wire logic       pop,
    output frag_desc_t      pop_desc,
    output logic            empty
);

    frag_desc_t        entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   fill_reg, fill_next;
    logic              do_push, do_pop;

    assign full     = (fill_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign empty    = (fill_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_desc = entry_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
            fill_next = fill_reg + (QPTR_W + 1)'(1);
        else if (do_pop && !do_push)
            fill_next = fill_reg - (QPTR_W + 1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_desc;
    end

endmodule

`default_nettype wire

@@ design/ihb_back.sv @@
// Back end: computes both checksums for a fragment and streams its header words.
// Depends on ihb_pkg and ihb_out_if; pops descriptors from ihb_queue.
`timescale 1ns / 1ps
`default_nettype none

module ihb_back
    import ihb_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cfg_t       cfg,
    input  wire logic       q_empty,
    input  wire frag_desc_t q_desc,
    output logic            q_pop,
    ihb_out_if.source       hdr
);

    back_state_t       state_reg, state_next;
    logic [WIDX_W-1:0] idx_reg, idx_next;
    frag_desc_t        desc_reg;
    logic [CSUM_W-1:0] ip_sum_reg;
    logic [CSUM_W-1:0] tp_sum_reg;
    logic [15:0]       ip_ck_reg;
    logic [15:0]       tp_ck_reg;

    logic              out_valid_reg, out_valid_next;
    logic [15:0]       out_word_reg;
    logic [LEN_W-1:0]  out_len_reg;
    logic              out_last_reg;

    logic              emit_load;
    logic              emit_last;
    logic [WIDX_W-1:0] nw;
    logic [7:0]        proto;
    logic [15:0]       tl;
    logic [15:0]       ip_total;
    logic [CSUM_W-1:0] ip_sum;
    logic [CSUM_W-1:0] tp_sum;
    logic [CSUM_W-1:0] ip_fold;
    logic [CSUM_W-1:0] tp_fold;
    logic [15:0]       tp_ck;
    logic [15:0]       word;

    // Per-protocol header shape
    assign nw       = cfg.use_tcp ? TCP_WORDS : UDP_WORDS;
    assign proto    = cfg.use_tcp ? PROTO_TCP : PROTO_UDP;
    assign tl       = (cfg.use_tcp ? TCP_HDR_BYTES : UDP_HDR_BYTES) + 16'(desc_reg.len);
    assign ip_total = tl + IP_HDR_BYTES;

    // Raw one's-complement sums, registered before folding
    assign ip_sum = ext16(VER_IHL_TOS) + ext16(ip_total) + ext16(IP_ID)
                  + ext16({IP_TTL, proto})
                  + ext16(cfg.src_addr[31:16]) + ext16(cfg.src_addr[15:0])
                  + ext16(desc_reg.dst_addr[31:16]) + ext16(desc_reg.dst_addr[15:0]);

    assign tp_sum = ext16(cfg.src_addr[31:16]) + ext16(cfg.src_addr[15:0])
                  + ext16(desc_reg.dst_addr[31:16]) + ext16(desc_reg.dst_addr[15:0])
                  + ext16({8'h00, proto}) + ext16(tl)
                  + ext16(cfg.source_port) + ext16(desc_reg.dst_port)
                  + (cfg.use_tcp ? (ext16(TCP_OFF_FLAGS) + ext16(TCP_WINDOW)) : ext16(tl))
                  + CSUM_W'(desc_reg.payload_sum);

    assign ip_fold = fold_step(ip_sum_reg);
    assign tp_fold = fold_step(tp_sum_reg);
    // UDP sends a zero checksum as all ones
    assign tp_ck   = (!cfg.use_tcp && (~tp_fold[15:0] == 16'h0000)) ? 16'hffff
                                                                      : ~tp_fold[15:0];

    // Header word at the current position
    always_comb
    begin
        case (idx_reg)
            5'd0:    word = VER_IHL_TOS;
            5'd1:    word = ip_total;
            5'd2:    word = IP_ID;
            5'd4:    word = {IP_TTL, proto};
            5'd5:    word = ip_ck_reg;
            5'd6:    word = cfg.src_addr[31:16];
            5'd7:    word = cfg.src_addr[15:0];
            5'd8:    word = desc_reg.dst_addr[31:16];
            5'd9:    word = desc_reg.dst_addr[15:0];
            5'd10:   word = cfg.source_port;
            5'd11:   word = desc_reg.dst_port;
            5'd12:   word = cfg.use_tcp ? 16'h0000 : tl;
            5'd13:   word = cfg.use_tcp ? 16'h0000 : tp_ck_reg;
            5'd16:   word = TCP_OFF_FLAGS;
            5'd17:   word = TCP_WINDOW;
            5'd18:   word = tp_ck_reg;
            default: word = 16'h0000;
        endcase
    end

    assign emit_last = (idx_reg == nw - WIDX_W'(1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:  if (!q_empty) state_next = BK_CALC;
            BK_CALC:  state_next = BK_FOLD1;
            BK_FOLD1: state_next = BK_FOLD2;
            BK_FOLD2: state_next = BK_EMIT;
            BK_EMIT:  if (emit_load && emit_last) state_next = BK_IDLE;
            default:  state_next = BK_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        q_pop     = 1'b0;
        emit_load = 1'b0;
        case (state_reg)
            BK_IDLE: q_pop     = !q_empty;
            BK_EMIT: emit_load = !out_valid_reg || hdr.ready;
            default:
            begin
                q_pop     = 1'b0;
                emit_load = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (state_reg == BK_IDLE)
            idx_next = '0;
        else if (emit_load)
            idx_next = idx_reg + WIDX_W'(1);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit_load)
            out_valid_next = 1'b1;
        else if (hdr.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
            desc_reg <= q_desc;
        case (state_reg)
            BK_CALC:
            begin
                ip_sum_reg <= ip_sum;
                tp_sum_reg <= tp_sum;
            end
            BK_FOLD1:
            begin
                ip_sum_reg <= ip_fold;
                tp_sum_reg <= tp_fold;
            end
            BK_FOLD2:
            begin
                ip_ck_reg <= ~ip_fold[15:0];
                tp_ck_reg <= tp_ck;
            end
            default:
            begin
                ip_sum_reg <= ip_sum_reg;
            end
        endcase
        if (emit_load)
        begin
            out_word_reg <= word;
            out_len_reg  <= desc_reg.len;
            out_last_reg <= emit_last;
        end
    end

    assign hdr.valid           = out_valid_reg;
    assign hdr.header_word     = out_word_reg;
    assign hdr.fragment_length = out_len_reg;
    assign hdr.last_word       = out_last_reg;

`ifndef NO_ASSERTIONS
    // Word position never runs past the header length
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_EMIT) |-> (idx_reg < nw))
        else $error("header word index beyond header length");

    // A descriptor is only taken while no fragment is in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == BK_IDLE) && !q_empty)
        else $error("descriptor popped while busy or queue empty");

    // UDP checksum word is never sent as zero
    assert property (@(posedge clk) disable iff (!rst_n)
        emit_load && !cfg.use_tcp && (idx_reg == 5'd13) |=> (out_word_reg != 16'h0000))
        else $error("zero UDP checksum emitted");
`endif

endmodule

`default_nettype wire

@@ design/ipv4_udp_tcp_header_builder.sv @@
// IPv4 UDP/TCP header builder. Payload bytes stream in on msg, one per cycle, and are cut
// into fragments of the configured size (a message's last byte closes a shorter one). For
// each fragment the block sends 14 header words (UDP) or 20 (TCP) on hdr, one per cycle
// while hdr is ready, with the IPv4 header checksum and the transport checksum over pseudo
// header, transport header and payload filled in. Bytes are taken every cycle while the
// four-entry fragment queue has room; the header back end takes a fragment in BK_IDLE,
// registers its raw sums in BK_CALC, folds them in BK_FOLD1 and BK_FOLD2 and then sends
// the words in BK_EMIT, the header word output being the limit for short fragments.
// Registers are written on cfg (0 source address, 1 source port, 2 use_tcp, 3 fragment
// size); they must be written only while the block is idle, which it does not enforce.
// Depends on ihb_pkg, ihb_if, ihb_front, ihb_queue and ihb_back.
`timescale 1ns / 1ps
`default_nettype none

module ipv4_udp_tcp_header_builder
    import ihb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    ihb_in_if.sink    msg,
    ihb_out_if.source hdr,
    ihb_cfg_if.sink   cfg
);

    cfg_t       cfg_reg;
    logic       q_push, q_full, q_pop, q_empty;
    frag_desc_t push_desc, pop_desc;

    assign cfg.ready = 1'b1;

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.src_addr    <= '0;
            cfg_reg.source_port <= '0;
            cfg_reg.use_tcp     <= 1'b0;
            cfg_reg.frag_size   <= FRAG_SIZE_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_SRC_ADDR:    cfg_reg.src_addr    <= cfg.data;
                REG_SOURCE_PORT: cfg_reg.source_port <= cfg.data[15:0];
                REG_USE_TCP:     cfg_reg.use_tcp     <= cfg.data[0];
                REG_FRAG_SIZE:   cfg_reg.frag_size   <= cfg.data[LEN_W-1:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    ihb_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .msg    (msg),
        .q_full (q_full),
        .q_push (q_push),
        .q_desc (push_desc)
    );

    ihb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_desc (push_desc),
        .full      (q_full),
        .pop       (q_pop),
        .pop_desc  (pop_desc),
        .empty     (q_empty)
    );

    ihb_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_desc  (pop_desc),
        .q_pop   (q_pop),
        .hdr     (hdr)
    );

endmodule

`default_nettype wire
